FILE: hdl/stft_pkg.sv
`timescale 1ns / 1ps

package stft_pkg;

  localparam int FFT_N      = 64;
  localparam int HALF_N     = FFT_N / 2;
  localparam int N_W        = $clog2(FFT_N);
  localparam int SAMPLE_W   = 16;
  localparam int WIN_W      = 17;
  localparam int TW_W       = 17;
  localparam int WORK_W     = SAMPLE_W + WIN_W;
  localparam int PROD_W     = WORK_W + TW_W;
  localparam int ACC_W      = PROD_W + N_W;
  localparam int RND_SHIFT  = 28;
  localparam int RND_W      = 24;
  localparam int SQ_W       = 2 * RND_W;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int STEP_W     = $clog2(SQRT_STEPS);
  localparam int MAG_W      = 21;
  localparam int BIN_W      = 6;
  localparam int FRAME_W    = 16;
  localparam int CNT_W      = 16;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint          Q30_ONE     = 64'sd1073741824;

  typedef logic signed [TW_W-1:0] tw_t;
  typedef tw_t [FFT_N-1:0]        tw_tab_t;
  typedef logic [WIN_W-1:0]       win_t;
  typedef win_t [FFT_N-1:0]       win_tab_t;

  typedef struct packed {
    logic               push;
    logic               clear;
    logic               win_en;
    logic               mac_en;
    logic               mac_clr;
    logic               rnd_en;
    logic               sq_en;
    logic               sqrt_init;
    logic               sqrt_en;
    logic               out_load;
    logic [N_W-1:0]     n;
    logic [N_W-1:0]     k;
    logic [FRAME_W-1:0] frame;
  } stft_cmd_t;

  typedef struct packed {
    logic out_free;
  } stft_status_t;

  // cos or sin of 2*pi*m/FFT_N in Q30: Taylor series on the quadrant remainder
  function automatic longint unit_q30(input int m, input bit want_sin);
    longint unsigned four, q, r, x, x2, tc, ts;
    longint c, s, co, si;
    four = longint'(4 * m);
    q = four / FFT_N;
    r = four - q * FFT_N;
    x = (r * PI_HALF_Q30 + FFT_N / 2) / FFT_N;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    c = Q30_ONE;
    s = longint'(x);
    tc = Q30_ONE;
    ts = x;
    // ten terms: divide by (2k-1)*2k for cos and 2k*(2k+1) for sin
    tc = tc * x2 / 64'd2;   ts = ts * x2 / 64'd6;
    c = c - longint'(tc);   s = s - longint'(ts);
    tc = tc * x2 / 64'd12;  ts = ts * x2 / 64'd20;
    c = c + longint'(tc);   s = s + longint'(ts);
    tc = tc * x2 / 64'd30;  ts = ts * x2 / 64'd42;
    c = c - longint'(tc);   s = s - longint'(ts);
    tc = tc * x2 / 64'd56;  ts = ts * x2 / 64'd72;
    c = c + longint'(tc);   s = s + longint'(ts);
    tc = tc * x2 / 64'd90;  ts = ts * x2 / 64'd110;
    c = c - longint'(tc);   s = s - longint'(ts);
    tc = tc * x2 / 64'd132; ts = ts * x2 / 64'd156;
    c = c + longint'(tc);   s = s + longint'(ts);
    tc = tc * x2 / 64'd182; ts = ts * x2 / 64'd210;
    c = c - longint'(tc);   s = s - longint'(ts);
    tc = tc * x2 / 64'd240; ts = ts * x2 / 64'd272;
    c = c + longint'(tc);   s = s + longint'(ts);
    tc = tc * x2 / 64'd306; ts = ts * x2 / 64'd342;
    c = c - longint'(tc);   s = s - longint'(ts);
    tc = tc * x2 / 64'd380; ts = ts * x2 / 64'd420;
    c = c + longint'(tc);   s = s + longint'(ts);
    if (c > Q30_ONE) c = Q30_ONE;
    if (c < -Q30_ONE) c = -Q30_ONE;
    if (s > Q30_ONE) s = Q30_ONE;
    if (s < -Q30_ONE) s = -Q30_ONE;
    case (q[1:0])
      2'd0:    begin co = c;  si = s;  end
      2'd1:    begin co = -s; si = c;  end
      2'd2:    begin co = -c; si = -s; end
      default: begin co = s;  si = -c; end
    endcase
    return want_sin ? si : co;
  endfunction

  function automatic longint q30_to_q15(input longint v);
    if (v < 0) return -((-v + 16384) >> 15);
    return (v + 16384) >> 15;
  endfunction

  function automatic tw_tab_t build_cos();
    tw_tab_t t;
    for (int m = 0; m < FFT_N; m++) t[m] = tw_t'(q30_to_q15(unit_q30(m, 1'b0)));
    return t;
  endfunction

  function automatic tw_tab_t build_sin();
    tw_tab_t t;
    for (int m = 0; m < FFT_N; m++) t[m] = tw_t'(q30_to_q15(unit_q30(m, 1'b1)));
    return t;
  endfunction

  function automatic win_tab_t build_win();
    win_tab_t t;
    for (int m = 0; m < FFT_N; m++) t[m] = win_t'((Q30_ONE - unit_q30(m, 1'b0) + 32768) >> 16);
    return t;
  endfunction

  localparam tw_tab_t  COS_T = build_cos();
  localparam tw_tab_t  SIN_T = build_sin();
  localparam win_tab_t WIN_T = build_win();

endpackage

FILE: hdl/stft_if.sv
`timescale 1ns / 1ps

interface stft_in_if import stft_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       pad;
  logic                       last;
  modport source (output valid, output sample, output pad, output last, input ready);
  modport sink (input valid, input sample, input pad, input last, output ready);
endinterface

interface stft_out_if import stft_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MAG_W-1:0]   magnitude;
  logic [BIN_W-1:0]   bin_index;
  logic [FRAME_W-1:0] frame_index;
  logic               last_bin;
  modport source (output valid, output magnitude, output bin_index, output frame_index,
                  output last_bin, input ready);
  modport sink (input valid, input magnitude, input bin_index, input frame_index,
                input last_bin, output ready);
endinterface

FILE: hdl/stft_datapath.sv
`timescale 1ns / 1ps

module stft_datapath import stft_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  stft_cmd_t                  cmd,
  output stft_status_t               status,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_pad,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [MAG_W-1:0]           out_magnitude,
  output logic [BIN_W-1:0]           out_bin_index,
  output logic [FRAME_W-1:0]         out_frame_index,
  output logic                       out_last_bin
);

  localparam logic [SQ_W-1:0]  MAG_MAX  = SQ_W'((64'd1 << MAG_W) - 1);
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SHIFT - 1);

  logic signed [SAMPLE_W-1:0] hist_mem [FFT_N];
  logic signed [WORK_W-1:0]   work_mem [FFT_N];

  logic [FFT_N-1:0]           hist_vld_r;
  logic [N_W-1:0]             wp_r;
  logic [N_W-1:0]             rd_addr;
  logic signed [SAMPLE_W-1:0] hist_q_r;
  logic                       hist_ok_r;
  logic [N_W-1:0]             wn_r;
  logic                       wv_r;
  logic signed [WORK_W-1:0]   hx, wx, win_prod;

  logic signed [WORK_W-1:0]   work_q_r;
  logic [N_W-1:0]             m_r;
  logic [2*N_W-1:0]           nk;
  logic                       mv_r;
  logic signed [PROD_W-1:0]   px, pc, ps;
  logic signed [PROD_W-1:0]   prod_re_r, prod_im_r;
  logic                       pv_r;
  logic signed [ACC_W-1:0]    acc_re_r, acc_im_r;

  logic [ACC_W-1:0]           abs_re, abs_im, rnd_re, rnd_im;
  logic [RND_W-1:0]           a_r, b_r;
  logic [SQ_W-1:0]            sa_r, sb_r;
  logic [SQ_W-1:0]            rv_r, rres_r, rbit_r, trial;
  logic [SQ_W-1:0]            mag_raw;

  logic                       out_valid_r;
  logic [MAG_W-1:0]           mag_r;
  logic [BIN_W-1:0]           bin_r;
  logic [FRAME_W-1:0]         frame_r;
  logic                       last_bin_r;

  // oldest sample sits at the write pointer
  assign rd_addr = wp_r + cmd.n;
  assign nk      = cmd.n * cmd.k;

  assign hx       = hist_ok_r ? WORK_W'(hist_q_r) : '0;
  assign wx       = WORK_W'($signed({1'b0, WIN_T[wn_r]}));
  assign win_prod = hx * wx;

  assign px = PROD_W'(work_q_r);
  assign pc = PROD_W'($signed(COS_T[m_r]));
  assign ps = PROD_W'($signed(SIN_T[m_r]));

  assign abs_re = acc_re_r[ACC_W-1] ? ACC_W'(-acc_re_r) : ACC_W'(acc_re_r);
  assign abs_im = acc_im_r[ACC_W-1] ? ACC_W'(-acc_im_r) : ACC_W'(acc_im_r);
  assign rnd_re = (abs_re + RND_HALF) >> RND_SHIFT;
  assign rnd_im = (abs_im + RND_HALF) >> RND_SHIFT;

  assign trial   = rres_r + rbit_r;
  assign mag_raw = (rres_r + SQ_W'(2)) >> 2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r  <= '0;
      wp_r        <= '0;
      wv_r        <= 1'b0;
      mv_r        <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        hist_vld_r <= '0;
        wp_r       <= '0;
      end else if (cmd.push) begin
        hist_vld_r[wp_r] <= 1'b1;
        wp_r             <= wp_r + 1'b1;
      end
      wv_r <= cmd.win_en;
      mv_r <= cmd.mac_en;
      pv_r <= mv_r;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      hist_mem[wp_r] <= in_pad ? '0 : in_sample;
    end
    if (cmd.win_en) begin
      hist_q_r  <= hist_mem[rd_addr];
      hist_ok_r <= hist_vld_r[rd_addr];
      wn_r      <= cmd.n;
    end
    if (wv_r) begin
      work_mem[wn_r] <= win_prod;
    end
    if (cmd.mac_en) begin
      work_q_r <= work_mem[cmd.n];
      m_r      <= nk[N_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mv_r) begin
      prod_re_r <= px * pc;
      prod_im_r <= px * ps;
    end
    if (cmd.mac_clr) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (pv_r) begin
      acc_re_r <= acc_re_r + ACC_W'(prod_re_r);
      acc_im_r <= acc_im_r - ACC_W'(prod_im_r);
    end
    if (cmd.rnd_en) begin
      a_r <= rnd_re[RND_W-1:0];
      b_r <= rnd_im[RND_W-1:0];
    end
    if (cmd.sq_en) begin
      sa_r <= SQ_W'(a_r) * SQ_W'(a_r);
      sb_r <= SQ_W'(b_r) * SQ_W'(b_r);
    end
    // one restoring square-root step per cycle
    if (cmd.sqrt_init) begin
      rv_r   <= sa_r + sb_r;
      rres_r <= '0;
      rbit_r <= SQ_W'(1) << (SQ_W - 2);
    end else if (cmd.sqrt_en) begin
      if (rv_r >= trial) begin
        rv_r   <= rv_r - trial;
        rres_r <= (rres_r >> 1) + rbit_r;
      end else begin
        rres_r <= rres_r >> 1;
      end
      rbit_r <= rbit_r >> 2;
    end
    if (cmd.out_load) begin
      mag_r      <= (mag_raw > MAG_MAX) ? MAG_MAX[MAG_W-1:0] : mag_raw[MAG_W-1:0];
      bin_r      <= BIN_W'(cmd.k);
      frame_r    <= cmd.frame;
      last_bin_r <= (cmd.k == N_W'(HALF_N));
    end
  end

  assign status.out_free  = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_magnitude    = mag_r;
  assign out_bin_index    = bin_r;
  assign out_frame_index  = frame_r;
  assign out_last_bin     = last_bin_r;

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded word not presented");

  a_wp_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push && !cmd.clear |=> wp_r == $past(wp_r) + 1'b1)
    else $error("write pointer did not advance");

  a_clear_hist: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> hist_vld_r == '0 && wp_r == '0)
    else $error("history not cleared");

endmodule

FILE: hdl/stft_ctrl.sv
`timescale 1ns / 1ps

module stft_ctrl import stft_pkg::*; #(
  parameter int HOP_SIZE = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_last,
  output logic         in_ready,
  output stft_cmd_t    cmd,
  input  stft_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE, S_WIN, S_WIN_DRAIN, S_MAC, S_MAC_DRAIN, S_RND, S_SQ, S_SQRT_INIT, S_SQRT, S_OUT
  } state_t;

  localparam logic [CNT_W-1:0]  HALF_CNT = CNT_W'(HALF_N);
  localparam logic [CNT_W-1:0]  WRAP_CNT = CNT_W'(HALF_N + HOP_SIZE);
  localparam logic [N_W-1:0]    N_LAST   = N_W'(FFT_N - 1);
  localparam logic [N_W-1:0]    K_LAST   = N_W'(HALF_N);
  localparam logic [STEP_W-1:0] SQ_LAST  = STEP_W'(SQRT_STEPS - 1);

  state_t             state_r;
  logic [N_W-1:0]     n_r, k_r;
  logic [STEP_W-1:0]  step_r;
  logic [CNT_W-1:0]   item_cnt_r;
  logic [FRAME_W-1:0] frame_r;
  logic               last_pend_r;

  logic               push, frame_go, finish;
  logic [CNT_W-1:0]   cnt_inc, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign push     = in_valid && in_ready;
  assign cnt_inc  = item_cnt_r + 1'b1;
  assign cnt_nxt  = (cnt_inc == WRAP_CNT) ? HALF_CNT : cnt_inc;
  assign frame_go = push && (cnt_nxt == HALF_CNT);
  assign finish   = (state_r == S_OUT) && status.out_free && (k_r == K_LAST);

  always_comb begin
    cmd           = '0;
    cmd.n         = n_r;
    cmd.k         = k_r;
    cmd.frame     = frame_r;
    cmd.push      = push;
    cmd.clear     = (push && in_last && !frame_go) || (finish && last_pend_r);
    cmd.win_en    = (state_r == S_WIN);
    cmd.mac_en    = (state_r == S_MAC);
    cmd.mac_clr   = (state_r == S_MAC) && (n_r == '0);
    cmd.rnd_en    = (state_r == S_RND);
    cmd.sq_en     = (state_r == S_SQ);
    cmd.sqrt_init = (state_r == S_SQRT_INIT);
    cmd.sqrt_en   = (state_r == S_SQRT);
    cmd.out_load  = (state_r == S_OUT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      k_r         <= '0;
      step_r      <= '0;
      item_cnt_r  <= '0;
      frame_r     <= '0;
      last_pend_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (push) begin
            item_cnt_r <= cnt_nxt;
            if (frame_go) begin
              state_r     <= S_WIN;
              n_r         <= '0;
              last_pend_r <= in_last;
            end else if (in_last) begin
              item_cnt_r <= '0;
              frame_r    <= '0;
            end
          end
        end
        S_WIN: begin
          n_r <= n_r + 1'b1;
          if (n_r == N_LAST) state_r <= S_WIN_DRAIN;
        end
        S_WIN_DRAIN: begin
          state_r <= S_MAC;
          k_r     <= '0;
          n_r     <= '0;
        end
        S_MAC: begin
          n_r <= n_r + 1'b1;
          if (n_r == N_LAST) begin
            state_r <= S_MAC_DRAIN;
            step_r  <= '0;
          end
        end
        S_MAC_DRAIN: begin
          // wait for the product and accumulate stages to empty
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(1)) state_r <= S_RND;
        end
        S_RND: state_r <= S_SQ;
        S_SQ: state_r <= S_SQRT_INIT;
        S_SQRT_INIT: begin
          state_r <= S_SQRT;
          step_r  <= '0;
        end
        S_SQRT: begin
          step_r <= step_r + 1'b1;
          if (step_r == SQ_LAST) state_r <= S_OUT;
        end
        S_OUT: begin
          if (status.out_free) begin
            if (k_r == K_LAST) begin
              state_r <= S_IDLE;
              if (last_pend_r) begin
                item_cnt_r <= '0;
                frame_r    <= '0;
              end else begin
                frame_r <= frame_r + 1'b1;
              end
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_MAC;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    frame_go |=> state_r == S_WIN && n_r == '0)
    else $error("frame not started");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> item_cnt_r < WRAP_CNT)
    else $error("item count out of range");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    finish && last_pend_r |=> item_cnt_r == '0 && frame_r == '0)
    else $error("counters not cleared after last word");

endmodule

FILE: hdl/stft_magnitude_frames.sv
`timescale 1ns / 1ps

// Short-time Fourier magnitudes over a 64-sample periodic Hann window.
// in_word carries one sample (or a pad word counting as zero) and a last flag;
// out_word carries one rounded bin magnitude with its bin and frame number.
// A word that completes no frame is taken and ready stays high. A word that
// completes a frame starts the frame engine: it windows the history into the
// work memory, then for each of the 33 bins runs the work memory through the
// single multiply-accumulate pair, rounds and squares the two sums, takes the
// bit-serial square root and loads the magnitude into the output register.
// Input ready stays low until the frame's final bin is loaded; a stalled
// receiver holds the engine at each bin until the output register frees.
// Reset (rst_n low, synchronous) empties the history (zeros), the counters and
// the output register; a word with last set empties the history and the
// counters, after its frame if it completes one, but not the output register.
module stft_magnitude_frames import stft_pkg::*; #(
  parameter int HOP_SIZE = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  stft_in_if.sink    in_word,
  stft_out_if.source out_word
);

  stft_cmd_t    cmd;
  stft_status_t status;
  logic         ready;

  assign in_word.ready = ready;

  stft_ctrl #(
    .HOP_SIZE (HOP_SIZE)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_word.valid),
    .in_last  (in_word.last),
    .in_ready (ready),
    .cmd      (cmd),
    .status   (status)
  );

  stft_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_sample       (in_word.sample),
    .in_pad          (in_word.pad),
    .out_ready       (out_word.ready),
    .out_valid       (out_word.valid),
    .out_magnitude   (out_word.magnitude),
    .out_bin_index   (out_word.bin_index),
    .out_frame_index (out_word.frame_index),
    .out_last_bin    (out_word.last_bin)
  );

endmodule

FILE: tb/stft_tb_if.sv
`timescale 1ns / 1ps

// The channel interfaces come with the block (stft_in_if, stft_out_if).
// This file holds the record of one input word, used by the testbench top.
package stft_tb_pkg;
  import stft_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       pad;
    logic                       last;
  } audio_word_t;
endpackage

FILE: tb/stft_checker.sv
`timescale 1ns / 1ps

module stft_checker import stft_pkg::*; #(
  parameter int HOP = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  stft_in_if.sink     in_mon,
  stft_out_if.sink    out_mon,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [MAG_W-1:0]   magnitude;
    logic [BIN_W-1:0]   bin_index;
    logic [FRAME_W-1:0] frame_index;
    logic               last_bin;
  } bin_result_t;

  bin_result_t bins_due[$];
  longint      history[FFT_N];
  longint      cos_tab[FFT_N];
  longint      sin_tab[FFT_N];
  longint      win_tab[FFT_N];
  int          word_count;
  int          frame_no;

  function automatic longint circle_q30(input int m, input bit want_sin);
    longint unsigned r, x, x2, tc, ts;
    longint c, s;
    int q;
    q  = (4 * m) / FFT_N;
    r  = 4 * m - q * FFT_N;
    x  = (r * 64'd1686629713 + FFT_N / 2) / FFT_N;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    c  = 64'sd1 << 30;
    s  = longint'(x);
    tc = 64'd1 << 30;
    ts = x;
    for (int k = 1; k <= 10; k++) begin
      tc = tc * x2 / ((2 * k - 1) * (2 * k));
      ts = ts * x2 / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        c -= longint'(tc);
        s -= longint'(ts);
      end else begin
        c += longint'(tc);
        s += longint'(ts);
      end
    end
    if (c > (64'sd1 << 30)) c = 64'sd1 << 30;
    if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
    if (c < -(64'sd1 << 30)) c = -(64'sd1 << 30);
    if (s < -(64'sd1 << 30)) s = -(64'sd1 << 30);
    case (q % 4)
      0: return want_sin ? s : c;
      1: return want_sin ? c : -s;
      2: return want_sin ? -s : -c;
      default: return want_sin ? -c : s;
    endcase
  endfunction

  function automatic longint to_q15(input longint v);
    return v < 0 ? -((-v + 16384) >>> 15) : (v + 16384) >>> 15;
  endfunction

  function automatic longint unsigned round_quarter(input longint v);
    longint unsigned u;
    u = v < 0 ? longint'(-v) : longint'(v);
    return (u + (64'd1 << 27)) >> 28;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // window the history, transform and queue one frame of magnitudes
  task automatic predict_frame();
    longint          windowed[FFT_N];
    longint          re, im;
    longint unsigned a, b, mag;
    bin_result_t     r;
    for (int n = 0; n < FFT_N; n++) windowed[n] = history[n] * win_tab[n];
    for (int k = 0; k <= HALF_N; k++) begin
      re = 0;
      im = 0;
      for (int n = 0; n < FFT_N; n++) begin
        re += windowed[n] * cos_tab[(k * n) % FFT_N];
        im -= windowed[n] * sin_tab[(k * n) % FFT_N];
      end
      a = round_quarter(re);
      b = round_quarter(im);
      mag = (root_floor(a * a + b * b) + 2) >> 2;
      if (mag > 64'h1FFFFF) mag = 64'h1FFFFF;
      r.magnitude   = mag[MAG_W-1:0];
      r.bin_index   = BIN_W'(k);
      r.frame_index = FRAME_W'(frame_no);
      r.last_bin    = (k == HALF_N);
      bins_due.push_back(r);
    end
    frame_no = (frame_no + 1) % 65536;
  endtask

  task automatic clear_signal();
    foreach (history[i]) history[i] = 0;
    word_count = 0;
    frame_no   = 0;
  endtask

  initial begin
    longint c;
    for (int m = 0; m < FFT_N; m++) begin
      c = circle_q30(m, 1'b0);
      cos_tab[m] = to_q15(c);
      sin_tab[m] = to_q15(circle_q30(m, 1'b1));
      win_tab[m] = ((64'sd1 << 30) - c + 32768) >>> 16;
    end
    clear_signal();
  end

  always @(posedge clk) begin
    bin_result_t got, want;
    if (!rst_n) begin
      clear_signal();
      bins_due.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        for (int n = 0; n < FFT_N - 1; n++) history[n] = history[n + 1];
        history[FFT_N - 1] = in_mon.pad ? 0 : longint'(in_mon.sample);
        word_count++;
        if (word_count == HALF_N + HOP) word_count = HALF_N;
        if (word_count == HALF_N) predict_frame();
        if (in_mon.last) clear_signal();
      end
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.magnitude, out_mon.bin_index, out_mon.frame_index, out_mon.last_bin};
        if (bins_due.size() == 0) begin
          $display("%0t: unexpected word, actual mag %0d bin %0d frame %0d last %0b",
                   $time, got.magnitude, got.bin_index, got.frame_index, got.last_bin);
          fail_count++;
        end else begin
          want = bins_due.pop_front();
          if (got != want) begin
            $display({"%0t: mismatch, expected mag %0d bin %0d frame %0d last %0b,",
                      " actual mag %0d bin %0d frame %0d last %0b"},
                     $time, want.magnitude, want.bin_index, want.frame_index,
                     want.last_bin, got.magnitude, got.bin_index, got.frame_index,
                     got.last_bin);
            fail_count++;
          end
        end
      end
    end
    pending = bins_due.size();
  end

endmodule

FILE: tb/tb_stft_magnitude_frames.sv
`timescale 1ns / 1ps

module tb_stft_magnitude_frames;
  import stft_pkg::*;
  import stft_tb_pkg::*;

  localparam int  HOP         = 16;
  localparam longint CYCLE_CAP = 64'd4_000_000;

  logic   clk;
  logic   rst_n;
  int     fail_count;
  int     pending;
  longint cycles;
  bit     hold_off;
  audio_word_t stimulus[$];

  stft_in_if  in_ch ();
  stft_out_if out_ch ();

  stft_magnitude_frames #(.HOP_SIZE(HOP)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch.sink),
    .out_word (out_ch.source)
  );

  stft_checker #(.HOP(HOP)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch.sink),
    .out_mon    (out_ch.sink),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("[stft_magnitude_frames] ERROR");
      $finish;
    end
  end

  function automatic audio_word_t make_word(input int s, input bit p, input bit l);
    audio_word_t w;
    w.sample = SAMPLE_W'(s);
    w.pad    = p;
    w.last   = l;
    return w;
  endfunction

  // one well-formed signal: samples of a chosen flavour, then HALF_N pad words
  task automatic queue_signal(input int len, input int flavour);
    int s;
    for (int i = 0; i < len; i++) begin
      case (flavour)
        0: s = $urandom_range(0, 65535) - 32768;
        1: s = (i % 2) ? 32767 : -32768;
        2: s = $urandom_range(0, 200) - 100;
        default: s = (i % 8 < 4) ? 20000 : -20000;
      endcase
      stimulus.push_back(make_word(s, 1'b0, 1'b0));
    end
    for (int i = 0; i < HALF_N; i++)
      stimulus.push_back(make_word($urandom, 1'b1, i == HALF_N - 1));
  endtask

  // receiver: random stalls, plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= (cycles % 512 < 256) ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  initial begin
    hold_off = 1'b0;
    wait (cycles > 5000);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (8000) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    audio_word_t w;
    int gap;
    int burst;
    rst_n  = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    in_ch.pad    = 1'b0;
    in_ch.last   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, a pad that carries a value, short signal ended by last
    stimulus.push_back(make_word(32767, 1'b0, 1'b0));
    stimulus.push_back(make_word(-32768, 1'b0, 1'b0));
    stimulus.push_back(make_word(0, 1'b0, 1'b0));
    stimulus.push_back(make_word(-1, 1'b1, 1'b0));
    stimulus.push_back(make_word(12345, 1'b0, 1'b1));
    stimulus.push_back(make_word(-32768, 1'b0, 1'b1));
    for (int i = 0; i < 14; i++)
      stimulus.push_back(make_word((i % 2) ? 32767 : -32768, 1'b0, 1'b0));
    // random: mostly whole signals, some long ones to wrap the hop count
    queue_signal(30, 0);
    queue_signal(20, 1);
    queue_signal(20, 3);
    for (int i = 0; i < 12; i++)
      stimulus.push_back(make_word($urandom, $urandom_range(0, 3) == 0,
                                   $urandom_range(0, 9) == 0));
    queue_signal(10, 2);

    burst = 0;
    while (stimulus.size() != 0) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30);
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst = $urandom_range(1, 20);
      end
      w = stimulus.pop_front();
      in_ch.valid  <= 1'b1;
      in_ch.sample <= w.sample;
      in_ch.pad    <= w.pad;
      in_ch.last   <= w.last;
      do @(posedge clk); while (!in_ch.ready);
      @(negedge clk);
      burst--;
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("[stft_magnitude_frames] OK");
    end else begin
      $display("[stft_magnitude_frames] ERROR");
    end
    $finish;
  end

endmodule
